// File: hdl/vbca_pkg.sv
// package: constants and types for the voxel binning block
package vbca_pkg;

  localparam int unsigned MaxGridDim = 32;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 32;

  typedef enum logic [CfgAddrW-1:0] {
    RegOriginX   = 3'd0,
    RegOriginY   = 3'd1,
    RegOriginZ   = 3'd2,
    RegInvSize   = 3'd3,
    RegThreshold = 3'd4,
    RegGridX     = 3'd5,
    RegGridY     = 3'd6,
    RegGridZ     = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    OpInsert = 1'b0,
    OpQuery  = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StIndex,
    StCheck,
    StRead,
    StLoad,
    StWrite,
    StDivStart,
    StDivWait,
    StOut
  } state_e;

  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic [31:0] inv_voxel_size;
    logic [15:0] count_threshold;
    logic [5:0]  grid_x_size;
    logic [5:0]  grid_y_size;
    logic [5:0]  grid_z_size;
  } cfg_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [4:0]  query_x;
    logic [4:0]  query_y;
    logic [4:0]  query_z;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  voxel_x;
    logic [4:0]  voxel_y;
    logic [4:0]  voxel_z;
    logic        out_of_range;
    logic [15:0] point_count;
    logic        occupied;
    logic [7:0]  mean_red;
    logic [7:0]  mean_green;
    logic [7:0]  mean_blue;
  } out_item_t;

endpackage

// File: hdl/vbca_if.sv
// interfaces: valid/ready channels for input and result items
interface vbca_in_if;
  logic                valid;
  logic                ready;
  vbca_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vbca_out_if;
  logic                valid;
  logic                ready;
  vbca_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/voxel_binning_color_average_top.sv
// top level: voxel binning with saturating counts and mean colour per voxel
//
//  channel  | dir | handshake        | payload
//  in_if    | in  | valid/ready      | opcode, point, colour, query index
//  out_if   | out | valid/ready      | voxel index, flags, count, means
//  cfg      | in  | cfg_we_i         | cfg_addr_i, cfg_data_i
//
// item taken in idle; steps for a dropped insert: 3 index, check, output; for a query:
// index, read, load, divider start, wait, output; for a kept insert: 3 index, check,
// read, load, write, divider start, wait, output; the divider wait is COUNT_BITS+8 shifts
// after reset a clearing pass zeroes all MAX_GRID_DIM^3 (32768) words of the memory
// one item at a time; a result waiting on out ready holds the next item at its output step
module voxel_binning_color_average_top #(
  parameter int unsigned MAX_GRID_DIM = vbca_pkg::MaxGridDim,
  parameter int unsigned COUNT_BITS   = vbca_pkg::CountBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vbca_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [vbca_pkg::CfgDataW-1:0]     cfg_data_i,
  vbca_in_if.sink                           in_if,
  vbca_out_if.source                        out_if
);
  localparam int unsigned IdxW  = $clog2(MAX_GRID_DIM);
  localparam int unsigned AddrW = 3 * IdxW;
  localparam int unsigned SumW  = COUNT_BITS + 8;
  localparam int unsigned WordW = COUNT_BITS + 3 * SumW;
  localparam logic [AddrW-1:0] LastAddr = {AddrW{1'b1}};

  vbca_pkg::cfg_t     cfg_q;
  vbca_pkg::state_e   state_q, state_d;
  vbca_pkg::in_item_t item_q;
  vbca_pkg::out_item_t res_q;
  vbca_pkg::out_item_t res_d;
  logic               res_valid_q;
  logic               res_load;
  logic [AddrW-1:0]   clr_q;
  logic [1:0]         axis_q;
  logic [63:0]        prod_q [3];
  logic               neg_q [3];
  logic [IdxW-1:0]    idx_q [3];
  logic               drop_q;
  logic               in_grid_q;
  logic [WordW-1:0]   word_q;
  logic [WordW-1:0]   rd_data;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic [WordW-1:0]   wr_data;
  logic               wr_en;
  logic               div_start, div_busy;
  logic [7:0]         q_r, q_g, q_b;
  logic [COUNT_BITS-1:0] cnt;
  logic [SumW-1:0]    sr, sg, sb;
  logic               occ;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x        <= '0;
      cfg_q.origin_y        <= '0;
      cfg_q.origin_z        <= '0;
      cfg_q.inv_voxel_size  <= 32'd65536;
      cfg_q.count_threshold <= 16'd1;
      cfg_q.grid_x_size     <= 6'd32;
      cfg_q.grid_y_size     <= 6'd32;
      cfg_q.grid_z_size     <= 6'd32;
    end else if (cfg_we_i) begin
      unique case (vbca_pkg::cfg_reg_e'(cfg_addr_i))
        vbca_pkg::RegOriginX:   cfg_q.origin_x        <= cfg_data_i;
        vbca_pkg::RegOriginY:   cfg_q.origin_y        <= cfg_data_i;
        vbca_pkg::RegOriginZ:   cfg_q.origin_z        <= cfg_data_i;
        vbca_pkg::RegInvSize:   cfg_q.inv_voxel_size  <= cfg_data_i;
        vbca_pkg::RegThreshold: cfg_q.count_threshold <= cfg_data_i[15:0];
        vbca_pkg::RegGridX:     cfg_q.grid_x_size     <= cfg_data_i[5:0];
        vbca_pkg::RegGridY:     cfg_q.grid_y_size     <= cfg_data_i[5:0];
        vbca_pkg::RegGridZ:     cfg_q.grid_z_size     <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // per axis operands
  logic [31:0] p_sel, o_sel;
  always_comb begin
    case (axis_q)
      2'd0: begin p_sel = item_q.px; o_sel = cfg_q.origin_x; end
      2'd1: begin p_sel = item_q.py; o_sel = cfg_q.origin_y; end
      default: begin
        p_sel = item_q.pz; o_sel = cfg_q.origin_z;
      end
    endcase
  end

  logic [32:0] diff;
  assign diff = {p_sel[31], p_sel} - {o_sel[31], o_sel};

  // axis size saturated to the grid limit
  function automatic logic [8:0] eff_size(input logic [5:0] s);
    logic [8:0] r;
    r = (9'(s) > 9'(MAX_GRID_DIM)) ? 9'(MAX_GRID_DIM) : 9'(s);
    return r;
  endfunction

  logic [2:0] bad;
  always_comb begin
    bad = '0;
    bad[0] = neg_q[0] || (prod_q[0][63:32] >= 32'(eff_size(cfg_q.grid_x_size)));
    bad[1] = neg_q[1] || (prod_q[1][63:32] >= 32'(eff_size(cfg_q.grid_y_size)));
    bad[2] = neg_q[2] || (prod_q[2][63:32] >= 32'(eff_size(cfg_q.grid_z_size)));
  end

  logic [AddrW-1:0] vox_addr;
  assign vox_addr = {idx_q[0], idx_q[1], idx_q[2]};

  assign cnt = word_q[WordW-1 -: COUNT_BITS];
  assign sr  = word_q[3*SumW-1 -: SumW];
  assign sg  = word_q[2*SumW-1 -: SumW];
  assign sb  = word_q[SumW-1:0];
  assign occ = (32'(cnt) >= 32'(cfg_q.count_threshold)) && in_grid_q;

  assign res_load = (state_q == vbca_pkg::StOut) && (!res_valid_q || out_if.ready);

  // state machine
  always_comb begin
    state_d   = state_q;
    rd_addr   = vox_addr;
    wr_en     = 1'b0;
    wr_addr   = vox_addr;
    wr_data   = '0;
    div_start = 1'b0;
    unique case (state_q)
      vbca_pkg::StClear: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        if (clr_q == LastAddr) state_d = vbca_pkg::StIdle;
      end
      vbca_pkg::StIdle: begin
        if (in_if.valid) state_d = vbca_pkg::StIndex;
      end
      vbca_pkg::StIndex: begin
        if (item_q.opcode == vbca_pkg::OpQuery) state_d = vbca_pkg::StRead;
        else if (axis_q == 2'd2) state_d = vbca_pkg::StCheck;
      end
      vbca_pkg::StCheck: begin
        state_d = (bad != '0) ? vbca_pkg::StOut : vbca_pkg::StRead;
      end
      vbca_pkg::StRead: begin
        state_d = vbca_pkg::StLoad;
      end
      vbca_pkg::StLoad: begin
        state_d = (item_q.opcode == vbca_pkg::OpQuery) ? vbca_pkg::StDivStart
                                                       : vbca_pkg::StWrite;
      end
      vbca_pkg::StWrite: begin
        wr_en = (32'(cnt) < ((32'd1 << COUNT_BITS) - 32'd1)) || (COUNT_BITS == 32 &&
                 cnt != '1);
        wr_data = {cnt + 1'b1, sr + SumW'(item_q.red), sg + SumW'(item_q.green),
                   sb + SumW'(item_q.blue)};
        state_d = vbca_pkg::StDivStart;
      end
      vbca_pkg::StDivStart: begin
        div_start = 1'b1;
        state_d   = vbca_pkg::StDivWait;
      end
      vbca_pkg::StDivWait: begin
        if (!div_busy) state_d = vbca_pkg::StOut;
      end
      vbca_pkg::StOut: begin
        if (res_load) state_d = vbca_pkg::StIdle;
      end
      default: state_d = vbca_pkg::StIdle;
    endcase
  end

  assign in_if.ready = (state_q == vbca_pkg::StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vbca_pkg::StClear;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      axis_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == vbca_pkg::StClear) clr_q <= clr_q + 1'b1;
      if (state_q == vbca_pkg::StIdle) axis_q <= '0;
      else if (state_q == vbca_pkg::StIndex) axis_q <= axis_q + 1'b1;
      if (res_load) res_valid_q <= 1'b1;
      else if (out_if.ready) res_valid_q <= 1'b0;
    end
  end

  logic [63:0] prod;
  assign prod = {32'd0, diff[31:0]} * {32'd0, cfg_q.inv_voxel_size};

  // result item
  always_comb begin
    res_d = '0;
    if (drop_q) begin
      res_d.out_of_range = 1'b1;
    end else begin
      res_d.voxel_x     = item_q.opcode ? item_q.query_x : 5'(idx_q[0]);
      res_d.voxel_y     = item_q.opcode ? item_q.query_y : 5'(idx_q[1]);
      res_d.voxel_z     = item_q.opcode ? item_q.query_z : 5'(idx_q[2]);
      res_d.point_count = (32'(cnt) > 32'hFFFF) ? 16'hFFFF : 16'(cnt);
      res_d.occupied    = occ;
      if (occ && cnt != '0) begin
        res_d.mean_red   = q_r;
        res_d.mean_green = q_g;
        res_d.mean_blue  = q_b;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      item_q <= in_if.data;
    end
    if (state_q == vbca_pkg::StIndex) begin
      prod_q[axis_q] <= prod;
      neg_q[axis_q]  <= diff[32];
      if (item_q.opcode == vbca_pkg::OpQuery) begin
        idx_q[0]  <= IdxW'(item_q.query_x);
        idx_q[1]  <= IdxW'(item_q.query_y);
        idx_q[2]  <= IdxW'(item_q.query_z);
        in_grid_q <= (32'(item_q.query_x) < 32'(MAX_GRID_DIM)) &&
                     (32'(item_q.query_y) < 32'(MAX_GRID_DIM)) &&
                     (32'(item_q.query_z) < 32'(MAX_GRID_DIM));
      end
    end
    if (state_q == vbca_pkg::StCheck) begin
      drop_q    <= (bad != '0) && (item_q.opcode == vbca_pkg::OpInsert);
      in_grid_q <= 1'b1;
      idx_q[0]  <= prod_q[0][32 +: IdxW];
      idx_q[1]  <= prod_q[1][32 +: IdxW];
      idx_q[2]  <= prod_q[2][32 +: IdxW];
    end
    if (state_q == vbca_pkg::StIdle) drop_q <= 1'b0;
    if (state_q == vbca_pkg::StLoad) begin
      word_q <= in_grid_q ? rd_data : '0;
    end
    if (wr_en && state_q == vbca_pkg::StWrite) word_q <= wr_data;
    if (res_load) res_q <= res_d;
  end

  assign out_if.valid = res_valid_q;
  assign out_if.data  = res_q;

  vbca_store #(
    .MaxGridDim (MAX_GRID_DIM),
    .CountBits  (COUNT_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  vbca_div #(
    .CountBits (COUNT_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .sum_r_i   (sr),
    .sum_g_i   (sg),
    .sum_b_i   (sb),
    .divisor_i (cnt),
    .busy_o    (div_busy),
    .quot_r_o  (q_r),
    .quot_g_o  (q_g),
    .quot_b_o  (q_b)
  );

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == vbca_pkg::StClear |-> !in_if.ready)
    else $error("item accepted during clearing pass");
  a_one_write_per_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && state_q == vbca_pkg::StWrite) |=> !wr_en)
    else $error("double write to store");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid)
    else $error("result dropped while stalled");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == vbca_pkg::StOut |-> !div_busy)
    else $error("result taken while divider busy");
`endif
endmodule

// File: hdl/vbca_div.sv
// module: restoring divider, three colour sums by one count, one bit per cycle
module vbca_div #(
  parameter int unsigned CountBits = vbca_pkg::CountBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [CountBits+7:0]   sum_r_i,
  input  logic [CountBits+7:0]   sum_g_i,
  input  logic [CountBits+7:0]   sum_b_i,
  input  logic [CountBits-1:0]   divisor_i,
  output logic                   busy_o,
  output logic [7:0]             quot_r_o,
  output logic [7:0]             quot_g_o,
  output logic [7:0]             quot_b_o
);
  localparam int unsigned SumW = CountBits + 8;
  localparam int unsigned CntW = $clog2(SumW + 1);

  logic [SumW-1:0]  num_q [3];
  logic [CountBits:0] rem_q [3];
  logic [CountBits-1:0] den_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(SumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q[0] <= sum_r_i;
      num_q[1] <= sum_g_i;
      num_q[2] <= sum_b_i;
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= '0;
      end
      den_q <= divisor_i;
    end else if (busy_q) begin
      for (int i = 0; i < 3; i++) begin
        logic [CountBits+1:0] trial;
        trial = {rem_q[i], num_q[i][SumW-1]} - {2'b00, den_q};
        if (!trial[CountBits+1]) begin
          rem_q[i] <= trial[CountBits:0];
          num_q[i] <= {num_q[i][SumW-2:0], 1'b1};
        end else begin
          rem_q[i] <= {rem_q[i][CountBits-1:0], num_q[i][SumW-1]};
          num_q[i] <= {num_q[i][SumW-2:0], 1'b0};
        end
      end
    end
  end

  assign busy_o   = busy_q;
  assign quot_r_o = num_q[0][7:0];
  assign quot_g_o = num_q[1][7:0];
  assign quot_b_o = num_q[2][7:0];
endmodule

// File: hdl/vbca_store.sv
// module: voxel store, one memory of count and colour sums with registered read
module vbca_store #(
  parameter int unsigned MaxGridDim = vbca_pkg::MaxGridDim,
  parameter int unsigned CountBits  = vbca_pkg::CountBits,
  localparam int unsigned AddrW     = 3 * $clog2(MaxGridDim),
  localparam int unsigned WordW     = CountBits + 3 * (CountBits + 8)
) (
  input  logic             clk_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [WordW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WordW-1:0] wr_data_i
);
  localparam int unsigned Depth = 1 << AddrW;

  logic [WordW-1:0] mem_q [Depth];
  logic [WordW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;
endmodule
